FILE: src/mpbf_pkg.sv
// package for the multi-pipe byte fifo: widths, command and status codes, shared structs
// no dependencies
`timescale 1ns / 1ps

package mpbf_pkg;

    localparam int NUM_PIPES_DEF  = 64;
    localparam int PIPE_DEPTH_DEF = 4096;
    localparam int MAX_READ_DEF   = 64;
    localparam int DESC_W         = 7;
    localparam int LIM_W          = 7;
    localparam int ST_W           = 3;
    localparam int CREATE_SPAN    = 64;

    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLOSE  = 2'd3
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_NOFREE  = 3'd2,
        ST_FULL    = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_EOS     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DECIDE,
        BK_READ
    } bk_state_t;

    // item as handed from front to back
    typedef struct packed {
        cmd_t             cmd;
        logic [DESC_W-1:0] desc;
        logic [7:0]       data;
        logic [LIM_W-1:0] lim;
    } item_t;

    // one result beat
    typedef struct packed {
        status_t          status;
        logic [DESC_W-1:0] rdesc;
        logic [7:0]       obyte;
        logic             last;
    } result_t;

endpackage

FILE: src/mpbf_front.sv
// front end: accepts command beats into a short queue toward the back end
// depends on mpbf_pkg
`timescale 1ns / 1ps

module mpbf_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  mpbf_pkg::item_t    in_item,
    output logic               q_valid,
    input  logic               q_ready,
    output mpbf_pkg::item_t    q_item
);

    localparam int QD = 2;

    mpbf_pkg::item_t q_mem [QD];
    logic            wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            push, pop;

    assign in_ready = (cnt_reg != 2'(QD));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_mem[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wp_reg] <= in_item;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 2'(QD))
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 && !push) |=> !q_valid)
        else $error("queue valid without push");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && !q_ready) |=> q_valid)
        else $error("queue head lost without pop");

endmodule

FILE: src/mpbf_back.sv
// back end: pipe state, byte store and result generation
// depends on mpbf_pkg
`timescale 1ns / 1ps

module mpbf_back #(
    parameter int NUM_PIPES  = mpbf_pkg::NUM_PIPES_DEF,
    parameter int PIPE_DEPTH = mpbf_pkg::PIPE_DEPTH_DEF,
    parameter int MAX_READ   = mpbf_pkg::MAX_READ_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  mpbf_pkg::item_t    q_item,
    output logic               r_valid,
    input  logic               r_ready,
    output mpbf_pkg::result_t  r_res
);

    localparam int PW    = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int AW    = $clog2(PIPE_DEPTH);
    localparam int CW    = AW + 1;
    localparam int SPAN  = (NUM_PIPES < mpbf_pkg::CREATE_SPAN) ? NUM_PIPES
                                                                : mpbf_pkg::CREATE_SPAN;
    localparam int MW    = PW + AW;
    localparam int RW    = $clog2(MAX_READ + 1);
    localparam int DESC_W_L = mpbf_pkg::DESC_W;

    // per-pipe pointers live in small memories, looked up when a command is taken
    logic [AW-1:0] rptr_mem [NUM_PIPES];
    logic [AW-1:0] wptr_mem [NUM_PIPES];
    logic [CW-1:0] fill_mem [NUM_PIPES];
    logic [NUM_PIPES-1:0] use_reg, wcl_reg, rcl_reg;

    // pointers of the pipe named by the current command
    logic [AW-1:0] rptr_q_reg, wptr_q_reg;
    logic [CW-1:0] fill_q_reg;
    logic [AW-1:0] rptr_inc, wptr_inc;
    logic [PW-1:0] q_pidx;

    logic [7:0] store [2**MW];
    logic [7:0] rd_data_reg;

    mpbf_pkg::bk_state_t st_reg, st_next;
    mpbf_pkg::item_t     it_reg;
    logic [PW-1:0]       p_reg, p_next;
    logic [RW-1:0]       left_reg, left_next;

    // output register
    logic               ov_reg;
    mpbf_pkg::result_t  ores_reg;
    logic               o_load;
    mpbf_pkg::result_t  o_res;

    // memory control
    logic            mem_we, mem_re;
    logic [MW-1:0]   mem_waddr, mem_raddr;
    logic            rd_pend_reg;

    // decode
    logic [DESC_W_L-2:0] idx_raw;
    logic                idx_ok, wend;
    logic [PW-1:0]       pidx;
    logic                free_found;
    logic [PW-1:0]       free_idx;
    logic [RW-1:0]       lim_sat;
    logic [CW-1:0]       cur_fill;

    assign q_pidx  = PW'(q_item.desc[DESC_W_L-1:1]);
    assign idx_raw = it_reg.desc[DESC_W_L-1:1];
    assign wend    = it_reg.desc[0];
    assign pidx    = PW'(idx_raw);
    assign idx_ok  = (32'(idx_raw) < NUM_PIPES) && use_reg[pidx];
    assign cur_fill = fill_q_reg;

    // ring wrap for any depth
    assign rptr_inc = (rptr_q_reg == AW'(PIPE_DEPTH - 1)) ? '0 : rptr_q_reg + AW'(1);
    assign wptr_inc = (wptr_q_reg == AW'(PIPE_DEPTH - 1)) ? '0 : wptr_q_reg + AW'(1);

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SPAN - 1; i >= 0; i--) begin
            if (!use_reg[i]) begin
                free_found = 1'b1;
                free_idx   = PW'(i);
            end
        end
    end

    always_comb begin
        if (it_reg.lim == '0) begin
            lim_sat = RW'(1);
        end else if ({1'b0, it_reg.lim} > 8'(MAX_READ)) begin
            lim_sat = RW'(MAX_READ);
        end else begin
            lim_sat = RW'(it_reg.lim);
        end
    end

    assign q_ready = (st_reg == mpbf_pkg::BK_IDLE);
    assign r_valid = ov_reg;
    assign r_res   = ores_reg;

    logic out_free;
    assign out_free = !ov_reg || r_ready;

    // state machine
    logic do_write, do_create, do_close, do_read_beat;
    always_comb begin
        st_next      = st_reg;
        p_next       = p_reg;
        left_next    = left_reg;
        o_load       = 1'b0;
        o_res        = '{status: mpbf_pkg::ST_OK, rdesc: '0, obyte: 8'd0, last: 1'b1};
        do_write     = 1'b0;
        do_create    = 1'b0;
        do_close     = 1'b0;
        do_read_beat = 1'b0;
        mem_re       = 1'b0;
        case (st_reg)
            mpbf_pkg::BK_IDLE: begin
                if (q_valid) begin
                    st_next = mpbf_pkg::BK_DECIDE;
                end
            end
            mpbf_pkg::BK_DECIDE: begin
                if (out_free) begin
                    st_next = mpbf_pkg::BK_IDLE;
                    case (it_reg.cmd)
                        mpbf_pkg::CMD_CREATE: begin
                            o_load = 1'b1;
                            if (free_found) begin
                                do_create   = 1'b1;
                                o_res.rdesc = DESC_W_L'({free_idx, 1'b0});
                            end else begin
                                o_res.status = mpbf_pkg::ST_NOFREE;
                            end
                        end
                        mpbf_pkg::CMD_WRITE: begin
                            o_load = 1'b1;
                            if (!idx_ok || !wend || wcl_reg[pidx]) begin
                                o_res.status = mpbf_pkg::ST_INVALID;
                            end else if (cur_fill >= CW'(PIPE_DEPTH)) begin
                                o_res.status = mpbf_pkg::ST_FULL;
                            end else begin
                                do_write = 1'b1;
                            end
                        end
                        mpbf_pkg::CMD_READ: begin
                            if (!idx_ok || wend || rcl_reg[pidx]) begin
                                o_load = 1'b1;
                                o_res.status = mpbf_pkg::ST_INVALID;
                            end else if (cur_fill == '0) begin
                                o_load = 1'b1;
                                o_res.status = wcl_reg[pidx] ? mpbf_pkg::ST_EOS
                                                             : mpbf_pkg::ST_EMPTY;
                            end else begin
                                p_next    = pidx;
                                left_next = (32'(cur_fill) < 32'(lim_sat)) ? RW'(cur_fill)
                                                                            : lim_sat;
                                st_next   = mpbf_pkg::BK_READ;
                            end
                        end
                        mpbf_pkg::CMD_CLOSE: begin
                            o_load = 1'b1;
                            if (!idx_ok) begin
                                o_res.status = mpbf_pkg::ST_INVALID;
                            end else begin
                                do_close = 1'b1;
                            end
                        end
                        default: begin
                            o_load = 1'b1;
                        end
                    endcase
                end
            end
            mpbf_pkg::BK_READ: begin
                // issue memory reads; each byte read is loaded into the output register once the output is free
                if (rd_pend_reg) begin
                    if (out_free) begin
                        o_load      = 1'b1;
                        o_res.obyte = rd_data_reg;
                        o_res.last  = (left_reg == RW'(1));
                        left_next   = left_reg - RW'(1);
                        if (left_reg == RW'(1)) begin
                            st_next = mpbf_pkg::BK_IDLE;
                        end
                    end
                end
                if (left_reg != '0 && (!rd_pend_reg || (out_free && left_reg != RW'(1)))) begin
                    mem_re       = 1'b1;
                    do_read_beat = 1'b1;
                end
            end
            default: begin
                st_next = mpbf_pkg::BK_IDLE;
            end
        endcase
    end

    assign mem_we    = do_write;
    assign mem_waddr = {pidx, wptr_q_reg};
    assign mem_raddr = {p_reg, rptr_q_reg};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store[mem_waddr] <= it_reg.data;
        end
        if (mem_re) begin
            rd_data_reg <= store[mem_raddr];
        end
    end

    // pointer memories: one address written per cycle, set up on create
    always_ff @(posedge aclk) begin
        if (do_create) begin
            rptr_mem[free_idx] <= '0;
            wptr_mem[free_idx] <= '0;
            fill_mem[free_idx] <= '0;
        end
        if (do_write) begin
            wptr_mem[pidx] <= wptr_inc;
            fill_mem[pidx] <= fill_q_reg + CW'(1);
        end
        if (do_read_beat) begin
            rptr_mem[p_reg] <= rptr_inc;
            fill_mem[p_reg] <= fill_q_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) begin
            it_reg     <= q_item;
            rptr_q_reg <= rptr_mem[q_pidx];
            wptr_q_reg <= wptr_mem[q_pidx];
            fill_q_reg <= fill_mem[q_pidx];
        end else if (do_read_beat) begin
            rptr_q_reg <= rptr_inc;
            fill_q_reg <= fill_q_reg - CW'(1);
        end
        if (o_load) begin
            ores_reg <= o_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= mpbf_pkg::BK_IDLE;
            ov_reg      <= 1'b0;
            p_reg       <= '0;
            left_reg    <= '0;
            rd_pend_reg <= 1'b0;
            use_reg     <= '0;
            wcl_reg     <= '0;
            rcl_reg     <= '0;
        end else begin
            st_reg   <= st_next;
            p_reg    <= p_next;
            left_reg <= left_next;
            if (o_load) begin
                ov_reg <= 1'b1;
            end else if (r_ready) begin
                ov_reg <= 1'b0;
            end
            if (mem_re) begin
                rd_pend_reg <= 1'b1;
            end else if (o_load && st_reg == mpbf_pkg::BK_READ) begin
                rd_pend_reg <= 1'b0;
            end
            if (do_create) begin
                use_reg[free_idx]  <= 1'b1;
                wcl_reg[free_idx]  <= 1'b0;
                rcl_reg[free_idx]  <= 1'b0;
            end
            if (do_close) begin
                if (wend) begin
                    wcl_reg[pidx] <= 1'b1;
                    if (rcl_reg[pidx]) use_reg[pidx] <= 1'b0;
                end else begin
                    rcl_reg[pidx] <= 1'b1;
                    if (wcl_reg[pidx]) use_reg[pidx] <= 1'b0;
                end
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && !r_ready) |=> (ov_reg && $stable(ores_reg)))
        else $error("result overwritten while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == mpbf_pkg::BK_READ) |-> (left_reg != '0))
        else $error("read burst with no bytes left");
    assert property (@(posedge aclk) disable iff (!aresetn)
        do_write |-> (fill_q_reg < CW'(PIPE_DEPTH)))
        else $error("write into full pipe");
    assert property (@(posedge aclk) disable iff (!aresetn)
        do_read_beat |-> (fill_q_reg != '0))
        else $error("read from empty pipe");

endmodule

FILE: src/multi_pipe_byte_fifo_unit.sv
// top level of the multi-pipe byte fifo
// depends on mpbf_pkg, mpbf_front, mpbf_back
`timescale 1ns / 1ps

// A pool of NUM_PIPES byte pipes behind one command stream. The back end first takes
// each command and looks up the pipe pointers, then decides, so a create, write or
// close shows its single result beat once the decision is registered, when the back
// end is free. A read first fetches a byte from the byte store, then gives one beat
// per cycle up to its limit while the result is not stalled; each byte is registered
// before it is shown and a stalled result holds the back end. The front queue holds
// two commands, so the sender can hand over two commands while the back end streams
// before it is held. The byte store and pipe pointers have no reset; pointers are
// cleared when a pipe is created, the in-use and closed flags at reset.

module multi_pipe_byte_fifo_unit #(
    parameter int NUM_PIPES  = mpbf_pkg::NUM_PIPES_DEF,
    parameter int PIPE_DEPTH = mpbf_pkg::PIPE_DEPTH_DEF,
    parameter int MAX_READ   = mpbf_pkg::MAX_READ_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // command[1:0], descriptor[8:2], data_byte[16:9], read_limit[23:17]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status[2:0], read_descriptor[9:3], out_byte[17:10], zeros
    output logic        m_tlast
);

    mpbf_pkg::item_t   in_item, q_item;
    mpbf_pkg::result_t res;
    logic              q_valid, q_ready;

    assign in_item.cmd  = mpbf_pkg::cmd_t'(s_tdata[1:0]);
    assign in_item.desc = s_tdata[8:2];
    assign in_item.data = s_tdata[16:9];
    assign in_item.lim  = s_tdata[23:17];

    mpbf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    mpbf_back #(
        .NUM_PIPES  (NUM_PIPES),
        .PIPE_DEPTH (PIPE_DEPTH),
        .MAX_READ   (MAX_READ)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .r_valid (m_tvalid),
        .r_ready (m_tready),
        .r_res   (res)
    );

    assign m_tdata = {6'd0, res.obyte, res.rdesc, res.status};
    assign m_tlast = res.last;

endmodule

FILE: tb/sv/tb_multi_pipe_byte_fifo_unit.sv
// self-checking testbench for multi_pipe_byte_fifo_unit: directed and random command beats,
// a scoreboard class with its own pipe pool predicts every result beat
// depends on mpbf_pkg and multi_pipe_byte_fifo_unit
`timescale 1ns / 1ps

module tb_multi_pipe_byte_fifo_unit;

    localparam int PIPES = 64;
    localparam int DEPTH = 4096;
    localparam int RMAX  = 64;

    class pipe_pool_sb;
        logic [7:0] bytes [int];
        int         rd_ptr [PIPES];
        int         wr_ptr [PIPES];
        int         fill [PIPES];
        bit         busy [PIPES];
        bit         w_shut [PIPES];
        bit         r_shut [PIPES];
        mpbf_pkg::result_t pending [$];
        int         errors;
        int         beats_seen;

        function new();
            errors = 0;
            beats_seen = 0;
            for (int i = 0; i < PIPES; i++) begin
                rd_ptr[i] = 0; wr_ptr[i] = 0; fill[i] = 0;
                busy[i] = 0; w_shut[i] = 0; r_shut[i] = 0;
            end
        endfunction

        function void push(mpbf_pkg::status_t st, logic [6:0] rd, logic [7:0] b, logic l);
            mpbf_pkg::result_t r;
            r.status = st; r.rdesc = rd; r.obyte = b; r.last = l;
            pending.push_back(r);
        endfunction

        // work out the result beats of one accepted command
        function void note_cmd(mpbf_pkg::cmd_t c, logic [6:0] d, logic [7:0] b,
                               logic [6:0] lim);
            int p, n, k;
            bit wend;
            p = d >> 1;
            wend = d[0];
            case (c)
                mpbf_pkg::CMD_CREATE: begin
                    for (k = 0; k < PIPES; k++)
                        if (!busy[k]) break;
                    if (k == PIPES) begin
                        push(mpbf_pkg::ST_NOFREE, 0, 0, 1);
                    end else begin
                        rd_ptr[k] = 0; wr_ptr[k] = 0; fill[k] = 0;
                        busy[k] = 1; w_shut[k] = 0; r_shut[k] = 0;
                        push(mpbf_pkg::ST_OK, 7'(k * 2), 0, 1);
                    end
                end
                mpbf_pkg::CMD_WRITE: begin
                    if (!busy[p] || !wend || w_shut[p]) begin
                        push(mpbf_pkg::ST_INVALID, 0, 0, 1);
                    end else if (fill[p] >= DEPTH) begin
                        push(mpbf_pkg::ST_FULL, 0, 0, 1);
                    end else begin
                        bytes[p * DEPTH + wr_ptr[p]] = b;
                        wr_ptr[p] = (wr_ptr[p] + 1) % DEPTH;
                        fill[p]++;
                        push(mpbf_pkg::ST_OK, 0, 0, 1);
                    end
                end
                mpbf_pkg::CMD_READ: begin
                    if (!busy[p] || wend || r_shut[p]) begin
                        push(mpbf_pkg::ST_INVALID, 0, 0, 1);
                    end else if (fill[p] == 0) begin
                        push(w_shut[p] ? mpbf_pkg::ST_EOS : mpbf_pkg::ST_EMPTY, 0, 0, 1);
                    end else begin
                        n = (lim < 1) ? 1 : (lim > RMAX) ? RMAX : int'(lim);
                        if (fill[p] < n) n = fill[p];
                        for (k = 0; k < n; k++) begin
                            push(mpbf_pkg::ST_OK, 0, bytes[p * DEPTH + rd_ptr[p]], k + 1 == n);
                            rd_ptr[p] = (rd_ptr[p] + 1) % DEPTH;
                            fill[p]--;
                        end
                    end
                end
                default: begin
                    if (!busy[p]) begin
                        push(mpbf_pkg::ST_INVALID, 0, 0, 1);
                    end else begin
                        if (wend) w_shut[p] = 1;
                        else r_shut[p] = 1;
                        if (w_shut[p] && r_shut[p]) busy[p] = 0;
                        push(mpbf_pkg::ST_OK, 0, 0, 1);
                    end
                end
            endcase
        endfunction

        function void report(string what);
            $display("mismatch: %s", what);
            errors++;
        endfunction

        function void check_beat(logic [23:0] data, logic l);
            mpbf_pkg::result_t e;
            beats_seen++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected beat data=%h last=%0d", data, l));
                return;
            end
            e = pending.pop_front();
            if (data[2:0] !== e.status || data[9:3] !== e.rdesc || data[17:10] !== e.obyte
                || data[23:18] !== 6'd0 || l !== e.last)
                report($sformatf("beat %0d: got st=%0d rd=%0d b=%h l=%0d, want st=%0d rd=%0d b=%h l=%0d",
                    beats_seen, data[2:0], data[9:3], data[17:10], l,
                    e.status, e.rdesc, e.obyte, e.last));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // command[1:0], descriptor[8:2], data_byte[16:9], read_limit[23:17]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // status[2:0], read_descriptor[9:3], out_byte[17:10], zeros
    logic        m_tlast;

    pipe_pool_sb sb;
    bit          idle_on;
    int          cmd_count;

    multi_pipe_byte_fifo_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("** multi_pipe_byte_fifo_unit: FAILED **");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= idle_on ? ($urandom_range(99) >= 36) : 1'b1;
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast);

    task automatic send(mpbf_pkg::cmd_t c, logic [6:0] d, logic [7:0] b, logic [6:0] lim);
        while (idle_on && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lim, b, d, c};
        do @(posedge aclk); while (!s_tready);
        sb.note_cmd(c, d, b, lim);
        cmd_count++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        int pick, p, live [$];
        sb = new();
        cmd_count = 0;
        idle_on = 1;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single pipe life cycle and the error paths
        send(mpbf_pkg::CMD_CREATE, 0, 0, 1);
        send(mpbf_pkg::CMD_WRITE, 1, 8'h00, 1);
        send(mpbf_pkg::CMD_WRITE, 1, 8'hff, 1);
        send(mpbf_pkg::CMD_WRITE, 1, 8'h5a, 1);
        send(mpbf_pkg::CMD_READ, 0, 0, 7'd0);        // zero limit reads one byte
        send(mpbf_pkg::CMD_READ, 0, 0, 7'd127);      // limit saturates
        send(mpbf_pkg::CMD_READ, 0, 0, 7'd64);       // empty
        send(mpbf_pkg::CMD_WRITE, 0, 8'h11, 1);      // write to read end
        send(mpbf_pkg::CMD_READ, 1, 0, 7'd4);        // read from write end
        send(mpbf_pkg::CMD_READ, 7'd127, 0, 7'd4);   // pipe not in use
        send(mpbf_pkg::CMD_CLOSE, 7'd126, 0, 1);     // close pipe not in use
        send(mpbf_pkg::CMD_WRITE, 1, 8'ha5, 1);
        send(mpbf_pkg::CMD_CLOSE, 1, 0, 1);
        send(mpbf_pkg::CMD_WRITE, 1, 8'h22, 1);      // write after writer closed
        send(mpbf_pkg::CMD_CLOSE, 1, 0, 1);          // second close is fine
        send(mpbf_pkg::CMD_READ, 0, 0, 7'd8);        // leftover data after writer closed
        send(mpbf_pkg::CMD_READ, 0, 0, 7'd8);        // end of stream
        send(mpbf_pkg::CMD_CLOSE, 0, 0, 1);
        send(mpbf_pkg::CMD_READ, 0, 0, 7'd8);        // freed pipe
        send(mpbf_pkg::CMD_CREATE, 0, 0, 1);
        send(mpbf_pkg::CMD_CLOSE, 0, 0, 1);
        send(mpbf_pkg::CMD_WRITE, 1, 8'h33, 1);      // reader closed, writes still go in
        send(mpbf_pkg::CMD_READ, 0, 0, 7'd1);        // read after reader closed
        send(mpbf_pkg::CMD_CLOSE, 1, 0, 1);
        drain();

        // exhaust the pool, then free every pipe again
        idle_on = 0;
        for (int i = 0; i <= PIPES; i++) send(mpbf_pkg::CMD_CREATE, 0, 0, 1);
        drain();
        for (int i = 0; i < 2 * PIPES; i++) send(mpbf_pkg::CMD_CLOSE, 7'(i), 0, 1);
        drain();

        // random: mostly well-formed traffic on live pipes, some noise
        for (int i = 0; i < 150; i++) begin
            idle_on = !(i >= 40 && i < 90);
            if (i == 100) drain();
            live.delete();
            for (int k = 0; k < PIPES; k++) if (sb.busy[k]) live.push_back(k);
            pick = $urandom_range(99);
            p = live.size() ? live[$urandom_range(live.size() - 1)] : 0;
            if (pick < 12 || live.size() == 0)
                send(mpbf_pkg::CMD_CREATE, 7'($urandom), 8'($urandom), 7'($urandom));
            else if (pick < 50)
                send(mpbf_pkg::CMD_WRITE, 7'(p * 2 + 1), 8'($urandom), 7'($urandom));
            else if (pick < 75)
                send(mpbf_pkg::CMD_READ, 7'(p * 2), 8'($urandom),
                     ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64)));
            else if (pick < 83)
                send(mpbf_pkg::CMD_CLOSE, 7'(p * 2 + $urandom_range(1)), 8'($urandom),
                     7'($urandom));
            else
                send(mpbf_pkg::cmd_t'($urandom_range(3)), 7'($urandom), 8'($urandom),
                     7'($urandom));
        end
        drain();

        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d expected beats never arrived", sb.pending.size()));
        $display("covered %0d commands and %0d result beats: pool exhaustion,",
                 cmd_count, sb.beats_seen);
        $display("closed ends, invalid descriptors, saturated limits and random traffic");
        if (sb.errors == 0) begin
            $display("** multi_pipe_byte_fifo_unit: PASSED **");
        end else begin
            $display("** multi_pipe_byte_fifo_unit: FAILED **");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/mpbf_pkg.sv
src/mpbf_front.sv
src/mpbf_back.sv
src/multi_pipe_byte_fifo_unit.sv
tb/sv/tb_multi_pipe_byte_fifo_unit.sv
